// ===== rtl/core/bptc_pkg.sv =====
// Package for the barometric compensation block: field widths, datapath
// widths, configuration register indexes and the calibration word bundle.
// No dependencies.
package bptc_pkg;

    // Port field widths
    localparam int RAW_W     = 24;
    localparam int COEFF_W   = 16;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 22;
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int DT_W   = 25;  // D2 - C5*256
    localparam int PROD_W = 42;  // dT times a 17-bit signed coefficient
    localparam int OFF_W  = 36;
    localparam int SENS_W = 35;
    localparam int SLO_W  = 18;  // low slice of SENS for the split multiply
    localparam int SHI_W  = SENS_W - SLO_W;
    localparam int PP_W   = 60;  // full D1*SENS product
    localparam int Q_W    = 39;  // D1*SENS/2^21
    localparam int DIFF_W = 40;  // Q - OFF

    // Pipeline depth, input register to output register
    localparam int STAGES = 7;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS      = 3'd0,
        CFG_OFFSET    = 3'd1,
        CFG_SENS_TEMP = 3'd2,
        CFG_OFF_TEMP  = 3'd3,
        CFG_REF_TEMP  = 3'd4,
        CFG_TEMP_SENS = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [COEFF_W-1:0] c1;  // pressure sensitivity
        logic [COEFF_W-1:0] c2;  // pressure offset
        logic [COEFF_W-1:0] c3;  // temp coeff of sensitivity
        logic [COEFF_W-1:0] c4;  // temp coeff of offset
        logic [COEFF_W-1:0] c5;  // reference temperature
        logic [COEFF_W-1:0] c6;  // temperature sensitivity
    } t_coeffs;

endpackage

// ===== rtl/core/bptc_in_if.sv =====
// Request channel carrying one raw pressure/temperature conversion pair.
// Depends on bptc_pkg.
interface bptc_in_if;
    logic                        valid;
    logic                        ready;
    logic [bptc_pkg::RAW_W-1:0]  raw_pressure;
    logic [bptc_pkg::RAW_W-1:0]  raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== rtl/core/bptc_out_if.sv =====
// Result channel carrying compensated temperature and pressure.
// Depends on bptc_pkg.
interface bptc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bptc_pkg::TEMP_W-1:0] temp_centideg;
    logic signed [bptc_pkg::PRES_W-1:0] pressure_centimbar;

    modport source (output valid, output temp_centideg, output pressure_centimbar,
                    input ready);
    modport sink   (input valid, input temp_centideg, input pressure_centimbar,
                    output ready);
endinterface

// ===== rtl/core/bptc_coeff_regs.sv =====
// Calibration register file: decodes writes into the six coefficient words.
// Depends on bptc_pkg.
module bptc_coeff_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bptc_pkg::COEFF_W-1:0]    i_cfg_data,
    output bptc_pkg::t_coeffs               o_coeffs
);

    bptc_pkg::t_coeffs r_coeffs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bptc_pkg::CFG_SENS:      r_coeffs.c1 <= i_cfg_data;
                bptc_pkg::CFG_OFFSET:    r_coeffs.c2 <= i_cfg_data;
                bptc_pkg::CFG_SENS_TEMP: r_coeffs.c3 <= i_cfg_data;
                bptc_pkg::CFG_OFF_TEMP:  r_coeffs.c4 <= i_cfg_data;
                bptc_pkg::CFG_REF_TEMP:  r_coeffs.c5 <= i_cfg_data;
                bptc_pkg::CFG_TEMP_SENS: r_coeffs.c6 <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_coeffs = r_coeffs;

endmodule

// ===== rtl/core/baro_pressure_temp_compensation_unit.sv =====
// Top level of the barometric first-order compensation block.
// Depends on bptc_pkg, bptc_in_if, bptc_out_if and bptc_coeff_regs.

// Accepts one raw pressure/temperature pair per clock while the output does not
// stall the pipeline, and returns the compensated temperature (0.01 degC) and
// pressure (0.01 mbar). The datapath has seven stages: dT, three dT products,
// OFF/SENS/TEMP, the D1*SENS product split into two 17/18-bit partial products,
// their sum, and two round-toward-zero scaling steps. Each stage holds its own
// valid bit and moves whenever the stage after it is empty or moving, so bubbles
// close up and a request is still taken while a finished result waits at the output.
// Calibration words must be written through the cfg port only while the block
// is idle; the block itself does not enforce this.
module baro_pressure_temp_compensation_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bptc_pkg::COEFF_W-1:0]    i_cfg_data,
    bptc_in_if.sink                         i_in,
    bptc_out_if.source                      o_out
);

    bptc_pkg::t_coeffs w_coeffs;

    bptc_coeff_regs u_coeff_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coeffs   (w_coeffs)
    );

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    logic [bptc_pkg::STAGES-1:0] r_v;
    logic [bptc_pkg::STAGES-1:0] n_v;
    logic [bptc_pkg::STAGES-1:0] w_en;

    always_comb begin
        w_en[bptc_pkg::STAGES-1] = !r_v[bptc_pkg::STAGES-1] || o_out.ready;
        for (int k = bptc_pkg::STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_v[0] = w_en[0] ? i_in.valid : r_v[0];
        for (int k = 1; k < bptc_pkg::STAGES; k++) begin
            n_v[k] = w_en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign i_in.ready = w_en[0];

    // ------------------------------------------------------------------
    // Stage 1: dT = D2 - C5*256
    // ------------------------------------------------------------------
    logic        [bptc_pkg::RAW_W-1:0] r_s1_d1;
    logic signed [bptc_pkg::DT_W-1:0]  r_s1_dt;
    logic signed [bptc_pkg::DT_W-1:0]  n_s1_dt;

    assign n_s1_dt = $signed({1'b0, i_in.raw_temperature})
                   - $signed({1'b0, w_coeffs.c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_d1 <= i_in.raw_pressure;
            r_s1_dt <= n_s1_dt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dT*C6, dT*C4, dT*C3
    // ------------------------------------------------------------------
    logic        [bptc_pkg::RAW_W-1:0]  r_s2_d1;
    logic signed [bptc_pkg::PROD_W-1:0] r_s2_p6;
    logic signed [bptc_pkg::PROD_W-1:0] r_s2_p4;
    logic signed [bptc_pkg::PROD_W-1:0] r_s2_p3;
    logic signed [bptc_pkg::PROD_W-1:0] n_s2_p6;
    logic signed [bptc_pkg::PROD_W-1:0] n_s2_p4;
    logic signed [bptc_pkg::PROD_W-1:0] n_s2_p3;

    assign n_s2_p6 = bptc_pkg::PROD_W'(r_s1_dt)
                   * bptc_pkg::PROD_W'($signed({1'b0, w_coeffs.c6}));
    assign n_s2_p4 = bptc_pkg::PROD_W'(r_s1_dt)
                   * bptc_pkg::PROD_W'($signed({1'b0, w_coeffs.c4}));
    assign n_s2_p3 = bptc_pkg::PROD_W'(r_s1_dt)
                   * bptc_pkg::PROD_W'($signed({1'b0, w_coeffs.c3}));

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_d1 <= r_s1_d1;
            r_s2_p6 <= n_s2_p6;
            r_s2_p4 <= n_s2_p4;
            r_s2_p3 <= n_s2_p3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: TEMP, OFF, SENS (shifts round toward zero)
    // ------------------------------------------------------------------
    logic        [bptc_pkg::RAW_W-1:0]  r_s3_d1;
    logic signed [bptc_pkg::TEMP_W-1:0] r_s3_temp;
    logic signed [bptc_pkg::OFF_W-1:0]  r_s3_off;
    logic signed [bptc_pkg::SENS_W-1:0] r_s3_sens;
    logic signed [bptc_pkg::TEMP_W-1:0] n_s3_temp;
    logic signed [bptc_pkg::OFF_W-1:0]  n_s3_off;
    logic signed [bptc_pkg::SENS_W-1:0] n_s3_sens;
    logic signed [bptc_pkg::PROD_W-1:0] w_bias6;
    logic signed [bptc_pkg::PROD_W-1:0] w_bias4;
    logic signed [bptc_pkg::PROD_W-1:0] w_bias3;
    logic signed [bptc_pkg::PROD_W-1:0] w_sh6;
    logic signed [bptc_pkg::PROD_W-1:0] w_sh4;
    logic signed [bptc_pkg::PROD_W-1:0] w_sh3;

    always_comb begin
        // negative values get 2^k-1 added before the arithmetic shift
        w_bias6 = r_s2_p6[bptc_pkg::PROD_W-1]
                ? $signed({{(bptc_pkg::PROD_W-23){1'b0}}, {23{1'b1}}}) : '0;
        w_bias4 = r_s2_p4[bptc_pkg::PROD_W-1]
                ? $signed({{(bptc_pkg::PROD_W-7){1'b0}}, {7{1'b1}}}) : '0;
        w_bias3 = r_s2_p3[bptc_pkg::PROD_W-1]
                ? $signed({{(bptc_pkg::PROD_W-8){1'b0}}, {8{1'b1}}}) : '0;
        w_sh6 = (r_s2_p6 + w_bias6) >>> 23;
        w_sh4 = (r_s2_p4 + w_bias4) >>> 7;
        w_sh3 = (r_s2_p3 + w_bias3) >>> 8;
        n_s3_temp = $signed(w_sh6[bptc_pkg::TEMP_W-1:0]) + bptc_pkg::TEMP_BASE;
        n_s3_off  = $signed({4'b0, w_coeffs.c2, 16'h0000})
                  + $signed(w_sh4[bptc_pkg::OFF_W-1:0]);
        n_s3_sens = $signed({4'b0, w_coeffs.c1, 15'h0000})
                  + $signed(w_sh3[bptc_pkg::SENS_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_d1   <= r_s2_d1;
            r_s3_temp <= n_s3_temp;
            r_s3_off  <= n_s3_off;
            r_s3_sens <= n_s3_sens;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: D1*SENS as two partial products
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::TEMP_W-1:0] r_s4_temp;
    logic signed [bptc_pkg::OFF_W-1:0]  r_s4_off;
    logic        [bptc_pkg::PROD_W-1:0] r_s4_pplo;
    logic signed [bptc_pkg::PROD_W-1:0] r_s4_pphi;
    logic        [bptc_pkg::PROD_W-1:0] n_s4_pplo;
    logic signed [bptc_pkg::PROD_W-1:0] n_s4_pphi;

    assign n_s4_pplo = bptc_pkg::PROD_W'(r_s3_d1)
                     * bptc_pkg::PROD_W'(r_s3_sens[bptc_pkg::SLO_W-1:0]);
    assign n_s4_pphi = bptc_pkg::PROD_W'($signed({1'b0, r_s3_d1}))
                     * bptc_pkg::PROD_W'(
                           $signed(r_s3_sens[bptc_pkg::SENS_W-1:bptc_pkg::SLO_W]));

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_temp <= r_s3_temp;
            r_s4_off  <= r_s3_off;
            r_s4_pplo <= n_s4_pplo;
            r_s4_pphi <= n_s4_pphi;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: combine partial products
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::TEMP_W-1:0] r_s5_temp;
    logic signed [bptc_pkg::OFF_W-1:0]  r_s5_off;
    logic signed [bptc_pkg::PP_W-1:0]   r_s5_prod;
    logic        [bptc_pkg::PP_W-1:0]   n_s5_prod;

    assign n_s5_prod =
        ({{(bptc_pkg::PP_W-bptc_pkg::PROD_W){r_s4_pphi[bptc_pkg::PROD_W-1]}}, r_s4_pphi}
            << bptc_pkg::SLO_W)
        + {{(bptc_pkg::PP_W-bptc_pkg::PROD_W){1'b0}}, r_s4_pplo};

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_temp <= r_s4_temp;
            r_s5_off  <= r_s4_off;
            r_s5_prod <= $signed(n_s5_prod);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: D1*SENS / 2^21
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::TEMP_W-1:0] r_s6_temp;
    logic signed [bptc_pkg::OFF_W-1:0]  r_s6_off;
    logic signed [bptc_pkg::Q_W-1:0]    r_s6_q;
    logic signed [bptc_pkg::PP_W-1:0]   w_bias21;
    logic signed [bptc_pkg::PP_W-1:0]   w_sh21;

    always_comb begin
        w_bias21 = r_s5_prod[bptc_pkg::PP_W-1]
                 ? $signed({{(bptc_pkg::PP_W-21){1'b0}}, {21{1'b1}}}) : '0;
        w_sh21   = (r_s5_prod + w_bias21) >>> 21;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s6_temp <= r_s5_temp;
            r_s6_off  <= r_s5_off;
            r_s6_q    <= $signed(w_sh21[bptc_pkg::Q_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: P = (Q - OFF) / 2^15, output register
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::TEMP_W-1:0] r_s7_temp;
    logic signed [bptc_pkg::PRES_W-1:0] r_s7_pres;
    logic signed [bptc_pkg::DIFF_W-1:0] w_diff;
    logic signed [bptc_pkg::DIFF_W-1:0] w_bias15;
    logic signed [bptc_pkg::DIFF_W-1:0] w_sh15;

    always_comb begin
        w_diff   = $signed({{(bptc_pkg::DIFF_W-bptc_pkg::Q_W){r_s6_q[bptc_pkg::Q_W-1]}},
                            r_s6_q})
                 - $signed({{(bptc_pkg::DIFF_W-bptc_pkg::OFF_W){r_s6_off[bptc_pkg::OFF_W-1]}},
                            r_s6_off});
        w_bias15 = w_diff[bptc_pkg::DIFF_W-1]
                 ? $signed({{(bptc_pkg::DIFF_W-15){1'b0}}, {15{1'b1}}}) : '0;
        w_sh15   = (w_diff + w_bias15) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s7_temp <= r_s6_temp;
            r_s7_pres <= $signed(w_sh15[bptc_pkg::PRES_W-1:0]);
        end
    end

    assign o_out.valid              = r_v[bptc_pkg::STAGES-1];
    assign o_out.temp_centideg      = r_s7_temp;
    assign o_out.pressure_centimbar = r_s7_pres;

endmodule

// ===== dv/baro_pressure_temp_compensation_unit_test.sv =====
// Self-checking testbench for the barometric first-order compensation unit.
// Depends on bptc_pkg, bptc_in_if, bptc_out_if and the RTL top level.
`timescale 1ns / 100ps

module baro_pressure_temp_compensation_unit_test;

    localparam logic [bptc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 3'd6;
    localparam logic [bptc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 3'd7;
    localparam logic [bptc_pkg::RAW_W-1:0]     RAW_MAX        = '1;
    localparam logic [bptc_pkg::COEFF_W-1:0]   COEFF_MAX      = '1;
    localparam int                             MAX_PRINTS     = 50;

    typedef struct {
        logic [bptc_pkg::RAW_W-1:0]         d1;
        logic [bptc_pkg::RAW_W-1:0]         d2;
        logic signed [bptc_pkg::TEMP_W-1:0] temp;
        logic signed [bptc_pkg::PRES_W-1:0] pres;
    } t_reading;

    // Holds the calibration words and the readings still owed by the block.
    class reading_checker;
        logic [bptc_pkg::COEFF_W-1:0] coeff [0:5];
        t_reading                     pending_readings [$];
        int                           errors;

        function new();
            foreach (coeff[i]) coeff[i] = '0;
            errors = 0;
        endfunction

        function void set_coeff(logic [bptc_pkg::CFG_IDX_W-1:0] idx,
                                logic [bptc_pkg::COEFF_W-1:0] val);
            // spare indexes are dropped by the block
            if (idx <= bptc_pkg::CFG_TEMP_SENS) coeff[idx] = val;
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction

        function void predict_reading(logic [bptc_pkg::RAW_W-1:0] raw_p,
                                      logic [bptc_pkg::RAW_W-1:0] raw_t);
            longint   d1, d2, c1, c2, c3, c4, c5, c6;
            longint   dt, temp, off, sens, pres;
            t_reading r;
            d1 = longint'(raw_p);
            d2 = longint'(raw_t);
            c1 = longint'(coeff[bptc_pkg::CFG_SENS]);
            c2 = longint'(coeff[bptc_pkg::CFG_OFFSET]);
            c3 = longint'(coeff[bptc_pkg::CFG_SENS_TEMP]);
            c4 = longint'(coeff[bptc_pkg::CFG_OFF_TEMP]);
            c5 = longint'(coeff[bptc_pkg::CFG_REF_TEMP]);
            c6 = longint'(coeff[bptc_pkg::CFG_TEMP_SENS]);
            // signed longint division truncates toward zero
            dt   = d2 - c5 * 256;
            temp = longint'(bptc_pkg::TEMP_BASE) + (dt * c6) / (longint'(1) << 23);
            off  = c2 * (longint'(1) << 16) + (c4 * dt) / (longint'(1) << 7);
            sens = c1 * (longint'(1) << 15) + (c3 * dt) / (longint'(1) << 8);
            pres = ((d1 * sens) / (longint'(1) << 21) - off) / (longint'(1) << 15);
            r.d1   = raw_p;
            r.d2   = raw_t;
            r.temp = temp[bptc_pkg::TEMP_W-1:0];
            r.pres = pres[bptc_pkg::PRES_W-1:0];
            pending_readings.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("%0t ERROR: %s", $realtime, msg);
        endtask

        task check_reading(logic signed [bptc_pkg::TEMP_W-1:0] temp,
                           logic signed [bptc_pkg::PRES_W-1:0] pres);
            t_reading r;
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: temp %0d pres %0d",
                                          temp, pres));
            end else begin
                r = pending_readings.pop_front();
                if (temp !== r.temp)
                    report_mismatch($sformatf("D1 %0d D2 %0d: temp %0d, expected %0d",
                                              r.d1, r.d2, temp, r.temp));
                if (pres !== r.pres)
                    report_mismatch($sformatf("D1 %0d D2 %0d: pressure %0d, expected %0d",
                                              r.d1, r.d2, pres, r.pres));
            end
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [bptc_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [bptc_pkg::COEFF_W-1:0]   cfg_data;

    bptc_in_if  in_ch ();
    bptc_out_if out_ch ();

    reading_checker sb;
    bit             steady;   // no idling on either side
    int             rx_hold;  // long receiver hold-off, in cycles

    baro_pressure_temp_compensation_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bptc_pkg::t_coeffs rand_coeffs(bit corners);
        bptc_pkg::t_coeffs            c;
        logic [bptc_pkg::COEFF_W-1:0] w [0:5];
        foreach (w[i]) begin
            w[i] = bptc_pkg::COEFF_W'($urandom_range(0, COEFF_MAX));
            if (corners && $urandom_range(0, 2) == 0)
                w[i] = $urandom_range(0, 1) ? COEFF_MAX : '0;
        end
        c.c1 = w[0]; c.c2 = w[1]; c.c3 = w[2];
        c.c4 = w[3]; c.c5 = w[4]; c.c6 = w[5];
        return c;
    endfunction

    // Request and result monitors; all sampling is on pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.predict_reading(in_ch.raw_pressure, in_ch.raw_temperature);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_reading(out_ch.temp_centideg, out_ch.pressure_centimbar);
    end

    initial begin : rx_drive
        int gap;
        gap = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end else if (gap > 0) begin
                out_ch.ready <= 1'b0;
                gap--;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                gap = pick_gap() - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_pair(input logic [bptc_pkg::RAW_W-1:0] d1,
                             input logic [bptc_pkg::RAW_W-1:0] d2);
        int gap;
        in_ch.valid           <= 1'b1;
        in_ch.raw_pressure    <= d1;
        in_ch.raw_temperature <= d2;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Advances the clock first so the monitor has logged the last accepted request.
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (bptc_pkg::STAGES + 2) @(posedge i_clk);
    endtask

    // Leaves the write enable high; load_coeffs lowers it once at the end.
    task automatic write_reg(input logic [bptc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bptc_pkg::COEFF_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.set_coeff(idx, data);
    endtask

    task automatic load_coeffs(input bptc_pkg::t_coeffs c);
        write_reg(bptc_pkg::CFG_SENS,      c.c1);
        write_reg(bptc_pkg::CFG_OFFSET,    c.c2);
        write_reg(bptc_pkg::CFG_SENS_TEMP, c.c3);
        write_reg(bptc_pkg::CFG_OFF_TEMP,  c.c4);
        write_reg(bptc_pkg::CFG_REF_TEMP,  c.c5);
        write_reg(bptc_pkg::CFG_TEMP_SENS, c.c6);
        write_reg(CFG_IDX_SPARE0, bptc_pkg::COEFF_W'($urandom_range(0, COEFF_MAX)));
        write_reg(CFG_IDX_SPARE1, bptc_pkg::COEFF_W'($urandom_range(0, COEFF_MAX)));
        cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    task automatic random_pairs(input int n, input bit pause_midway);
        logic [bptc_pkg::RAW_W-1:0] d1, d2;
        int sel;
        for (int i = 0; i < n; i++) begin
            if (pause_midway && i == n / 2) wait_drain();
            sel = $urandom_range(0, 9);
            d1  = bptc_pkg::RAW_W'($urandom_range(0, RAW_MAX));
            d2  = bptc_pkg::RAW_W'($urandom_range(0, RAW_MAX));
            if (sel == 0) d1 = $urandom_range(0, 1) ? RAW_MAX : '0;
            if (sel == 1) d2 = $urandom_range(0, 1) ? RAW_MAX : '0;
            // near the reference temperature dT changes sign
            if (sel >= 2 && sel <= 4)
                d2 = bptc_pkg::RAW_W'({sb.coeff[bptc_pkg::CFG_REF_TEMP], 8'h00}
                                      + $urandom_range(0, 8191) - 4096);
            send_pair(d1, d2);
        end
    endtask

    initial begin
        bptc_pkg::t_coeffs c;
        sb       = new();
        steady   = 1'b0;
        rx_hold  = 0;
        i_rst_n  <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= bptc_pkg::CFG_SENS;
        cfg_data <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.raw_pressure    <= '0;
        in_ch.raw_temperature <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero calibration out of reset
        send_pair('0, '0);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, '0);
        send_pair('0, RAW_MAX);
        wait_drain();

        // typical factory calibration
        c = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
              c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
        load_coeffs(c);
        send_pair('0, '0);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair('0, RAW_MAX);
        send_pair(RAW_MAX, '0);
        send_pair(24'd9085466, 24'd8569150);
        send_pair(24'd8000000, 24'd8566784);  // dT zero
        send_pair(RAW_MAX, 24'd8566783);
        send_pair(24'd123456, 24'd8566785);
        wait_drain();

        // every word at full scale: lowest temperature at D2 zero
        c = '{c1: COEFF_MAX, c2: COEFF_MAX, c3: COEFF_MAX,
              c4: COEFF_MAX, c5: COEFF_MAX, c6: COEFF_MAX};
        load_coeffs(c);
        send_pair('0, '0);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, '0);
        send_pair('0, RAW_MAX);
        send_pair(RAW_MAX, 24'hFFFF00);
        wait_drain();

        // no offset, no reference: highest temperature and pressure
        c = '{c1: COEFF_MAX, c2: '0, c3: COEFF_MAX, c4: '0, c5: '0, c6: COEFF_MAX};
        load_coeffs(c);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair('0, RAW_MAX);
        send_pair(RAW_MAX, '0);
        wait_drain();

        load_coeffs(rand_coeffs(1'b0));
        random_pairs(75, 1'b0);
        wait_drain();

        // back-to-back on both sides
        steady = 1'b1;
        load_coeffs(rand_coeffs(1'b0));
        random_pairs(75, 1'b0);
        wait_drain();

        // receiver holds off while the sender keeps offering
        rx_hold = 150;
        load_coeffs(rand_coeffs(1'b1));
        random_pairs(40, 1'b0);
        steady = 1'b0;
        random_pairs(35, 1'b0);
        wait_drain();

        load_coeffs(rand_coeffs(1'b0));
        random_pairs(75, 1'b1);
        wait_drain();

        load_coeffs(rand_coeffs(1'b1));
        random_pairs(75, 1'b0);
        wait_drain();

        load_coeffs(rand_coeffs(1'b0));
        random_pairs(75, 1'b0);
        wait_drain();
        repeat (bptc_pkg::STAGES * 2) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bptc_pkg.sv
rtl/core/bptc_in_if.sv
rtl/core/bptc_out_if.sv
rtl/core/bptc_coeff_regs.sv
rtl/core/baro_pressure_temp_compensation_unit.sv
dv/baro_pressure_temp_compensation_unit_test.sv
